[design/udiv_pkg.sv]
// Shared types and constants for the unsigned restoring divider.
// No dependencies; every other design file imports this package.
`default_nettype none

package udiv_pkg;

    // Width of the operand fields on the ports. The datapath width may be smaller.
    localparam int unsigned PORT_WIDTH = 64;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] dividend;
        logic [PORT_WIDTH-1:0] divisor;
    } t_div_in;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] quotient;
        logic                  divide_by_zero;
    } t_div_out;

endpackage

`default_nettype wire

[design/udiv_cell.sv]
// One cell of the divider chain: shifts one dividend bit into the partial remainder,
// does a trial subtract, and registers the result for the next cell. Uses udiv_pkg.
`default_nettype none

module udiv_cell
    import udiv_pkg::*;
#(
    parameter int unsigned W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Upstream side
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_rem,
    input  wire logic [W-1:0] i_qn,
    input  wire logic [W-1:0] i_den,
    input  wire logic         i_dbz,
    // Downstream side
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_rem,
    output logic [W-1:0]      o_qn,
    output logic [W-1:0]      o_den,
    output logic              o_dbz
);

    logic         r_valid;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_qn;
    logic [W-1:0] r_den;
    logic         r_dbz;

    logic         w_carry;
    logic [W-1:0] w_shift;
    logic [W:0]   w_diff;
    logic         w_ge;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_qn;

    // The qn word holds the unused dividend bits at the top and the quotient bits
    // built so far at the bottom; each cell shifts one place.
    always_comb begin
        w_carry = i_rem[W-1];
        w_shift = {i_rem[W-2:0], i_qn[W-1]};
        w_diff  = {w_carry, w_shift} - {1'b0, i_den};
        w_ge    = ~w_diff[W];
        n_rem   = w_ge ? w_diff[W-1:0] : w_shift;
        n_qn    = {i_qn[W-2:0], w_ge};
    end

    // The cell takes a new beat when it is empty or its contents move on.
    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem <= n_rem;
            r_qn  <= n_qn;
            r_den <= i_den;
            r_dbz <= i_dbz;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_qn    = r_qn;
    assign o_den   = r_den;
    assign o_dbz   = r_dbz;

endmodule

`default_nettype wire

[design/unsigned_restoring_divider.sv]
// Unsigned restoring divider: top level with the cell chain and output register.
// Depends on udiv_pkg and udiv_cell.
//
// Usage:
//   The input channel (i_valid, o_ready, i_data) carries a dividend and a divisor.
//   The output channel (o_valid, i_ready, o_data) returns the truncated quotient
//   and a divide_by_zero flag; a zero divisor gives a zero quotient with the flag set.
//   Only the low DATA_WIDTH bits of each operand are used; upper quotient bits are zero.
//   Every input beat produces exactly one output beat, in order.
//
//   With no stall, each beat is registered in each of the DATA_WIDTH cells of the
//   subtract chain in turn and then in the output register.
//   Throughput is one beat per cycle while the receiver does not stall, set by the
//   chain where every cell handles one quotient bit of a different division in each cycle.
//   Each cell holds its beat while the next one is full and stalled, so when the
//   receiver stalls, empty cells ahead still fill and the input keeps accepting
//   until the chain and the output register are all full.
//   Reset clears all valid flags; data registers are not reset.
`default_nettype none

module unsigned_restoring_divider
    import udiv_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_div_in  i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_div_out      o_data
);

    localparam int unsigned W = DATA_WIDTH;

    logic         w_valid [0:W];
    logic         w_ready [0:W];
    logic [W-1:0] w_rem   [0:W];
    logic [W-1:0] w_qn    [0:W];
    logic [W-1:0] w_den   [0:W];
    logic         w_dbz   [0:W];

    logic         r_out_valid;
    t_div_out     r_out;
    t_div_out     n_out;

    assign w_valid[0] = i_valid;
    assign o_ready    = w_ready[0];
    assign w_rem[0]   = '0;
    assign w_qn[0]    = i_data.dividend[W-1:0];
    assign w_den[0]   = i_data.divisor[W-1:0];
    assign w_dbz[0]   = (i_data.divisor[W-1:0] == '0);

    for (genvar k = 0; k < W; k++) begin : g_cell
        udiv_cell #(
            .W (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_qn    (w_qn[k]),
            .i_den   (w_den[k]),
            .i_dbz   (w_dbz[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_qn    (w_qn[k+1]),
            .o_den   (w_den[k+1]),
            .o_dbz   (w_dbz[k+1])
        );
    end

    // A zero divisor drives every trial subtract to succeed, so the flag
    // overrides the all-ones pattern the chain produces.
    always_comb begin
        n_out                = '0;
        n_out.divide_by_zero = w_dbz[W];
        if (!w_dbz[W]) begin
            n_out.quotient[W-1:0] = w_qn[W];
        end
    end

    assign w_ready[W] = ~r_out_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[W]) begin
            r_out_valid <= w_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[W] && w_valid[W]) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_dbz_zero_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.divide_by_zero) |-> (o_data.quotient == '0))
        else $error("divide by zero with nonzero quotient");

    a_upper_bits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.quotient >> W) == '0))
        else $error("quotient bits above the datapath width are set");

    a_empty_head_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[1] |-> o_ready)
        else $error("first cell empty but input not ready");

    a_output_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[W] && w_ready[W]) |=> o_valid)
        else $error("last cell handed off a beat that did not reach the output");

endmodule

`default_nettype wire
